// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: depth, field widths, command codes
// and the control bundle broadcast to every cell. No dependencies.
`default_nettype none

package spq_pkg;

  localparam int DEPTH          = 16;
  localparam int VAL_W          = 32;
  localparam int CNT_W          = $clog2(DEPTH + 1);
  localparam int ENTRY_COUNT_W  = 5;
  localparam int OUT_W          = 72;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } spq_cmd_t;

  typedef logic signed [VAL_W-1:0] spq_val_t;

  // Broadcast to the cell row; ins/rem are already qualified by the handshake
  // and by the full/empty checks.
  typedef struct packed {
    logic     ins;
    logic     rem;
    spq_val_t value;
  } spq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One storage cell of the sorted row: holds one entry, compares it with the
// incoming value and shifts toward its neighbors. Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic     clk,
  input  wire spq_ctl_t ctl,
  input  wire logic     occ,          // this cell holds a live entry
  input  wire logic     left_take,    // left neighbor takes a new entry
  input  wire spq_val_t left_entry,
  input  wire spq_val_t right_entry,
  output logic          take,
  output spq_val_t      entry_r,
  output spq_val_t      entry_nxt
);

  // Insert point is the first cell that is empty or holds a greater value.
  assign take = !occ || (entry_r > ctl.value);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (take && left_take) begin
        entry_nxt = left_entry;
      end else if (take) begin
        entry_nxt = ctl.value;
      end
    end else if (ctl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: the row of spq_cell instances, the
// occupancy counter and the result register. Depends on spq_pkg, spq_cell.
//
//  channel | dir | tdata                         | tuser
//  --------+-----+-------------------------------+-------------
//  in_     | in  | value[31:0]                   | command[0]
//  out_    | out | accepted, removed_value,      | -
//          |     | head_value, is_empty, count   |
//
// Each request is handled at once: every cell compares and shifts together,
// so one request per cycle is sustained while the result register is free.
// The result is registered on acceptance and holds while out_tready
// is low; a new request is accepted whenever the result register drains.
// Reset clears the count and the result valid; cell contents are not reset.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [VAL_W-1:0]  in_tdata,    // [31:0] value
  input  wire logic [0:0]        in_tuser,    // [0] command
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata    // [0] accepted, [32:1] removed_value,
                                              // [64:33] head_value, [65] is_empty,
                                              // [70:66] entry_count, [71] zero
);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic              in_acc, full, empty, acc;
  spq_cmd_t          cmd;
  spq_ctl_t          ctl;
  spq_val_t          removed, head;
  logic [DEPTH-1:0]  take;
  spq_val_t          entry     [DEPTH];
  spq_val_t          entry_nxt [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = spq_cmd_t'(in_tuser[0]);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  assign ctl.ins   = in_acc && (cmd == CMD_INSERT) && !full;
  assign ctl.rem   = in_acc && (cmd == CMD_REMOVE) && !empty;
  assign ctl.value = spq_val_t'(in_tdata);
  assign acc       = ctl.ins || ctl.rem;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic     lt;
      spq_val_t le, re;
      if (i == 0) begin : g_first
        assign lt = 1'b0;
        assign le = '0;
      end else begin : g_mid
        assign lt = take[i-1];
        assign le = entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign re = '0;
      end else begin : g_inner
        assign re = entry[i+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occ         (count_r > CNT_W'(i)),
        .left_take   (lt),
        .left_entry  (le),
        .right_entry (re),
        .take        (take[i]),
        .entry_r     (entry[i]),
        .entry_nxt   (entry_nxt[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign removed = ctl.rem ? entry[0] : '0;
  assign head    = (count_nxt != '0) ? entry_nxt[0] : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, ENTRY_COUNT_W'(count_nxt), (count_nxt == '0),
                       head, removed, acc};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Occupancy never exceeds the row length.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  // The two front cells stay in ascending order.
  a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > CNT_W'(1)) |-> (entry[0] <= entry[1]))
    else $error("front cells out of order");

  // Empty flag in the result agrees with the reported count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[65] == (out_tdata[70:66] == 5'd0)))
    else $error("empty flag disagrees with count");

  // An accepted request changes the count (the logic steps it by exactly one).
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (count_r != $past(count_r)))
    else $error("count did not move on an accepted request");

endmodule

`default_nettype wire
